@@ rtl/core/tdpt_pkg.sv @@
// shared types for the trial division prime test
// state encoding and the command/status bundles between controller and datapath
// no dependencies
package tdpt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_NEXT,
        ST_FINISH
    } tdpt_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic advance;
    } tdpt_cmd_t;

    typedef struct packed {
        logic below_two;
        logic bound_ok;
        logic rem_zero;
        logic last_step;
    } tdpt_status_t;

    localparam int FIRST_DIVISOR = 2;

endpackage

@@ rtl/core/tdpt_dpath.sv @@
// datapath: candidate, divisor, divisor square and a one-bit-per-cycle
// restoring remainder unit
// depends on tdpt_pkg
module tdpt_dpath
    import tdpt_pkg::*;
#(
    parameter int NUMBER_BITS = 31
)
(
    input  logic                   clk,
    input  logic [NUMBER_BITS-1:0] candidate,
    input  tdpt_cmd_t              cmd,
    output tdpt_status_t           status
);

    localparam int N     = NUMBER_BITS;
    localparam int CNT_W = $clog2(N);

    logic [N-1:0]     n_reg, n_next;
    logic [N-1:0]     d_reg, d_next;
    logic [N:0]       sq_reg, sq_next;
    logic [N-1:0]     rem_reg, rem_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [N:0] trial;
    logic [N:0] d_ext;
    logic [N:0] diff;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign d_ext = {1'b0, d_reg};
    assign diff  = trial - d_ext;

    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        sq_next  = sq_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            n_next  = candidate;
            d_next  = N'(FIRST_DIVISOR);
            sq_next = (N+1)'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
            quo_next = n_reg;
            cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            if (trial >= d_ext)
            begin
                rem_next = diff[N-1:0];
            end
            else
            begin
                rem_next = trial[N-1:0];
            end
            quo_next = {quo_reg[N-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.advance)
        begin
            // (d+1)^2 = d^2 + 2d + 1
            d_next  = d_reg + 1'b1;
            sq_next = sq_reg + {d_reg, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign status.below_two = (n_reg[N-1:1] == '0);
    assign status.bound_ok  = (sq_reg <= {1'b0, n_reg});
    assign status.rem_zero  = (rem_reg == '0);
    assign status.last_step = (cnt_reg == CNT_W'(N - 1));

endmodule

@@ rtl/core/tdpt_ctrl.sv @@
// controller: sequences bound check, remainder and divisor advance,
// and holds the result register of the output channel
// depends on tdpt_pkg
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         is_prime,
    input  tdpt_status_t status,
    output tdpt_cmd_t    cmd
);

    tdpt_state_t state_reg, state_next;
    logic        verdict_reg, verdict_next;
    logic        out_valid_reg, out_valid_next;
    logic        is_prime_reg, is_prime_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.below_two || !status.bound_ok)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.last_step)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (status.rem_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && out_stall;
        is_prime_next  = is_prime_reg;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CHECK:
            begin
                if (status.below_two)
                begin
                    verdict_next = 1'b0;
                end
                else if (!status.bound_ok)
                begin
                    verdict_next = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_NEXT:
            begin
                if (status.rem_zero)
                begin
                    verdict_next = 1'b0;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = verdict_reg;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg  <= verdict_next;
        is_prime_reg <= is_prime_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

@@ rtl/core/trial_division_prime_test.sv @@
// top level of the trial division prime test
// depends on tdpt_pkg, tdpt_ctrl, tdpt_dpath
//
// input channel: candidate with in_valid / in_stall; a beat is taken when
// in_valid is high and in_stall low. output channel: is_prime with
// out_valid / out_stall, one beat per input beat, in order.
// divisors d = 2, 3, ... are tried while d*d <= candidate; the square is
// kept incrementally. each divisor takes one bound check, NUMBER_BITS
// steps of the serial restoring remainder unit, and one test of the
// remainder that also advances d. 0 and 1 are rejected at the first check.
// one candidate is worked on at a time; the next beat is taken as soon as
// the result sits in the output register, even while it is stalled.
// a result that finds the output register full and stalled waits there.
// reset clears the controller state register and the output valid; no other state.
module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int NUMBER_BITS = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [NUMBER_BITS-1:0] candidate,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   is_prime
);

    tdpt_cmd_t    cmd;
    tdpt_status_t status;

    tdpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime),
        .status    (status),
        .cmd       (cmd)
    );

    tdpt_dpath #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dpath (
        .clk       (clk),
        .candidate (candidate),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
